// File: rtl/hier1d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hier1d_pkg: shared types, constants and helpers
// Word types, control word layout, microcode field codes and fixed-point
// helpers for the hierarchical 1-D shape function block.
// ----------------------------------------------------------------------------
package hier1d_pkg;

  localparam int MAX_ORDER_DEF = 15;

  // Widths: x and the other narrow multiplier operand, recurrence words,
  // products, index and result fields.
  localparam int AW   = 18;
  localparam int TW   = 32;
  localparam int PW   = AW + TW;
  localparam int FI_W = 4;
  localparam int RW   = 24;
  localparam int PC_W = 4;

  typedef struct packed {
    logic signed [AW-1:0] x_position;
    logic [FI_W-1:0]      poly_order;
    logic [31:0]          node_id_first;
    logic [31:0]          node_id_second;
  } in_t;

  typedef struct packed {
    logic [FI_W-1:0]      func_index;
    logic signed [RW-1:0] shape_value;
    logic signed [RW-1:0] shape_derivative;
    logic                 last_of_run;
  } out_t;

  // Multiplier operand A select.
  localparam logic [1:0] MA_X    = 2'd0;
  localparam logic [1:0] MA_BUB  = 2'd1;
  localparam logic [1:0] MA_NEGX = 2'd2;
  localparam logic [1:0] MA_Y    = 2'd3;

  // Multiplier operand B select.
  localparam logic [2:0] MB_X  = 3'd0;
  localparam logic [2:0] MB_TA = 3'd1;
  localparam logic [2:0] MB_DA = 3'd2;
  localparam logic [2:0] MB_TB = 3'd3;
  localparam logic [2:0] MB_DB = 3'd4;

  // Datapath operation on the registered product.
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_BUB    = 3'd1;
  localparam logic [2:0] OP_VAL    = 3'd2;
  localparam logic [2:0] OP_DER    = 3'd3;
  localparam logic [2:0] OP_DERADD = 3'd4;
  localparam logic [2:0] OP_TNEW   = 3'd5;
  localparam logic [2:0] OP_ADV    = 3'd6;

  // Result word emission.
  localparam logic [2:0] EM_NONE = 3'd0;
  localparam logic [2:0] EM_PHI0 = 3'd1;
  localparam logic [2:0] EM_PHI1 = 3'd2;
  localparam logic [2:0] EM_BUB  = 3'd3;
  localparam logic [2:0] EM_ONE  = 3'd4;

  // Jump conditions.
  localparam logic [2:0] C_NEXT    = 3'd0;
  localparam logic [2:0] C_ALWAYS  = 3'd1;
  localparam logic [2:0] C_WAIT    = 3'd2;
  localparam logic [2:0] C_ORD0    = 3'd3;
  localparam logic [2:0] C_ORD1    = 3'd4;
  localparam logic [2:0] C_NOTLAST = 3'd5;

  // Microcode step addresses.
  localparam logic [PC_W-1:0] S_IDLE = 4'd0;
  localparam logic [PC_W-1:0] S_XSQ  = 4'd1;
  localparam logic [PC_W-1:0] S_PHI0 = 4'd2;
  localparam logic [PC_W-1:0] S_PHI1 = 4'd3;
  localparam logic [PC_W-1:0] S_B0   = 4'd4;
  localparam logic [PC_W-1:0] S_B1   = 4'd5;
  localparam logic [PC_W-1:0] S_B2   = 4'd6;
  localparam logic [PC_W-1:0] S_B3   = 4'd7;
  localparam logic [PC_W-1:0] S_B4   = 4'd8;
  localparam logic [PC_W-1:0] S_B5   = 4'd9;
  localparam logic [PC_W-1:0] S_END  = 4'd10;
  localparam logic [PC_W-1:0] S_ONE  = 4'd11;

  typedef struct packed {
    logic [1:0]      mul_a;
    logic [2:0]      mul_b;
    logic [2:0]      op;
    logic [2:0]      emit;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic ord_zero;
    logic ord_one;
    logic not_last;
  } stat_t;

  // Round p / 2^sh half up (toward +infinity).
  function automatic logic signed [PW:0] rnd_shr(input logic signed [PW-1:0] p,
                                                 input int sh);
    logic signed [PW:0] s;
    s = {p[PW-1], p} + ((PW+1)'(1) <<< (sh - 1));
    return s >>> sh;
  endfunction

  // Saturate to the signed 24-bit result range.
  function automatic logic signed [RW-1:0] sat24(input logic signed [PW:0] v);
    logic signed [RW-1:0] r;
    if (!v[PW] && (|v[PW-1:RW-1])) begin
      r = {1'b0, {(RW-1){1'b1}}};
    end else if (v[PW] && !(&v[PW-1:RW-1])) begin
      r = {1'b1, {(RW-1){1'b0}}};
    end else begin
      r = v[RW-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/hier1d_ucode_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hier1d_ucode_rom: microcode store
// One control word per step: multiplier operands, datapath operation,
// result emission and the jump condition with its target.
// ----------------------------------------------------------------------------
module hier1d_ucode_rom (
  input  logic [hier1d_pkg::PC_W-1:0] pc,
  output hier1d_pkg::ctl_t            ctl
);
  import hier1d_pkg::*;

  function automatic ctl_t cw(input logic [1:0] ma, input logic [2:0] mb,
                              input logic [2:0] op, input logic [2:0] em,
                              input logic [2:0] cd, input logic [PC_W-1:0] tg);
    ctl_t c;
    c.mul_a  = ma;
    c.mul_b  = mb;
    c.op     = op;
    c.emit   = em;
    c.cond   = cd;
    c.target = tg;
    return c;
  endfunction

  always_comb begin
    case (pc)
      S_IDLE: ctl = cw(MA_X,    MB_X,  OP_NONE,   EM_NONE, C_WAIT,    S_IDLE);
      S_XSQ:  ctl = cw(MA_X,    MB_X,  OP_NONE,   EM_NONE, C_ORD0,    S_ONE);
      S_PHI0: ctl = cw(MA_X,    MB_X,  OP_BUB,    EM_PHI0, C_NEXT,    S_IDLE);
      S_PHI1: ctl = cw(MA_X,    MB_X,  OP_NONE,   EM_PHI1, C_ORD1,    S_IDLE);
      // Bubble loop: value, derivative terms, then the Chebyshev step.
      S_B0:   ctl = cw(MA_BUB,  MB_TA, OP_NONE,   EM_NONE, C_NEXT,    S_IDLE);
      S_B1:   ctl = cw(MA_BUB,  MB_DA, OP_VAL,    EM_NONE, C_NEXT,    S_IDLE);
      S_B2:   ctl = cw(MA_NEGX, MB_TA, OP_DER,    EM_NONE, C_NEXT,    S_IDLE);
      S_B3:   ctl = cw(MA_Y,    MB_TB, OP_DERADD, EM_NONE, C_NEXT,    S_IDLE);
      S_B4:   ctl = cw(MA_Y,    MB_DB, OP_TNEW,   EM_BUB,  C_NEXT,    S_IDLE);
      S_B5:   ctl = cw(MA_X,    MB_X,  OP_ADV,    EM_NONE, C_NOTLAST, S_B0);
      S_END:  ctl = cw(MA_X,    MB_X,  OP_NONE,   EM_NONE, C_ALWAYS,  S_IDLE);
      S_ONE:  ctl = cw(MA_X,    MB_X,  OP_NONE,   EM_ONE,  C_ALWAYS,  S_IDLE);
      default: ctl = cw(MA_X,   MB_X,  OP_NONE,   EM_NONE, C_ALWAYS,  S_IDLE);
    endcase
  end

endmodule

// File: rtl/hier1d_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hier1d_sequencer: step counter and jump logic
// Holds the step counter, reads the microcode store and picks the next
// step from the current word's condition and the datapath status.
// ----------------------------------------------------------------------------
module hier1d_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  hier1d_pkg::stat_t stat,
  output hier1d_pkg::ctl_t  ctl,
  output logic              busy
);
  import hier1d_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  hier1d_ucode_rom u_rom (
    .pc  (pc_r),
    .ctl (ctl)
  );

  always_comb begin
    case (ctl.cond)
      C_NEXT:    take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_WAIT:    take = !start;
      C_ORD0:    take = stat.ord_zero;
      C_ORD1:    take = stat.ord_one;
      C_NOTLAST: take = stat.not_last;
      default:   take = 1'b1;
    endcase
    pc_nxt = take ? ctl.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign busy = (pc_r != S_IDLE);

`ifndef NO_ASSERTIONS
  // Leaving idle happens only on a start.
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_IDLE && !start) |=> (pc_r == S_IDLE))
    else $error("sequencer left idle without start");

  // Every run begins with the x*x step.
  a_first_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_IDLE && start) |=> (pc_r == S_XSQ))
    else $error("run did not begin at the first step");

  // The loop tail either repeats the loop or ends the run.
  a_loop_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == S_B5) |=> (pc_r == S_B0 || pc_r == S_END))
    else $error("bad exit from bubble loop");
`endif

endmodule

// File: rtl/hier1d_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hier1d_datapath: shared multiplier, recurrence registers and result port
// Loads one point, runs the Chebyshev recurrence through a single
// registered 18x32 multiplier under microcode control and emits words.
// ----------------------------------------------------------------------------
module hier1d_datapath #(
  parameter int MAX_ORDER = hier1d_pkg::MAX_ORDER_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hier1d_pkg::in_t   in_item,
  input  hier1d_pkg::ctl_t  ctl,
  output hier1d_pkg::stat_t stat,
  output logic              out_valid,
  output hier1d_pkg::out_t  out_item
);
  import hier1d_pkg::*;

  localparam logic signed [AW-1:0] OneX     = AW'(65536);
  localparam logic signed [AW-1:0] MinX     = -AW'(65536);
  localparam logic signed [TW-1:0] OneT     = TW'(65536);
  localparam logic signed [PW:0]   BubBias  = (PW+1)'(64'h1_0002_0000);
  localparam logic signed [AW:0]   PhiBias  = (AW+1)'(65537);
  localparam logic signed [RW-1:0] OneR     = RW'(65536);
  localparam logic signed [RW-1:0] HalfR    = RW'(32768);

  logic signed [AW-1:0] x_r, negx_r, y_r, bub_r;
  logic                 flip_r;
  logic [FI_W-1:0]      order_r, j_r;
  logic signed [TW-1:0] ta_r, tb_r, da_r, db_r, tnew_r;
  logic signed [PW-1:0] prod_r;
  logic signed [PW:0]   val_r, der_r;
  logic                 out_valid_r;
  out_t                 out_r;

  logic signed [AW-1:0] xc, nx;
  logic [FI_W-1:0]      ord_c;
  logic                 flip_c;
  logic signed [AW-1:0] mul_a;
  logic signed [TW-1:0] mul_b;
  logic signed [PW:0]   r15;
  logic signed [AW:0]   phi0, phi1;

  // Clamp the point and the order on the way in.
  always_comb begin
    if (in_item.x_position > OneX) begin
      xc = OneX;
    end else if (in_item.x_position < MinX) begin
      xc = MinX;
    end else begin
      xc = in_item.x_position;
    end
    nx     = -xc;
    flip_c = (in_item.node_id_second < in_item.node_id_first);
    ord_c  = (int'(in_item.poly_order) > MAX_ORDER) ? FI_W'(MAX_ORDER)
                                                    : in_item.poly_order;
  end

  always_comb begin
    case (ctl.mul_a)
      MA_X:    mul_a = x_r;
      MA_BUB:  mul_a = bub_r;
      MA_NEGX: mul_a = negx_r;
      MA_Y:    mul_a = y_r;
      default: mul_a = x_r;
    endcase
    case (ctl.mul_b)
      MB_X:    mul_b = TW'(x_r);
      MB_TA:   mul_b = ta_r;
      // In the flipped orientation the derivative is taken against -y.
      MB_DA:   mul_b = flip_r ? -da_r : da_r;
      MB_TB:   mul_b = tb_r;
      MB_DB:   mul_b = db_r;
      default: mul_b = ta_r;
    endcase
    r15  = rnd_shr(prod_r, 15);
    phi0 = (PhiBias - (AW+1)'(x_r)) >>> 1;
    phi1 = (PhiBias + (AW+1)'(x_r)) >>> 1;
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    if (load) begin
      x_r     <= xc;
      negx_r  <= nx;
      y_r     <= flip_c ? nx : xc;
      flip_r  <= flip_c;
      order_r <= ord_c;
      j_r     <= FI_W'(2);
      ta_r    <= OneT;
      tb_r    <= TW'(flip_c ? nx : xc);
      da_r    <= '0;
      db_r    <= OneT;
    end else begin
      case (ctl.op)
        OP_BUB:    bub_r <= AW'((BubBias - {prod_r[PW-1], prod_r}) >>> 18);
        OP_VAL:    val_r <= rnd_shr(prod_r, 16);
        OP_DER:    der_r <= rnd_shr(prod_r, 16);
        OP_DERADD: der_r <= der_r + rnd_shr(prod_r, 17);
        OP_TNEW:   tnew_r <= TW'(r15 - (PW+1)'(ta_r));
        OP_ADV: begin
          ta_r <= tb_r;
          tb_r <= tnew_r;
          da_r <= db_r;
          db_r <= TW'(r15 + ((PW+1)'(tb_r) <<< 1) - (PW+1)'(da_r));
          j_r  <= j_r + FI_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Result register: one word per emitting step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctl.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.emit)
      EM_PHI0: begin
        out_r.func_index       <= FI_W'(0);
        out_r.shape_value      <= RW'(phi0);
        out_r.shape_derivative <= -HalfR;
        out_r.last_of_run      <= (order_r == FI_W'(1));
      end
      EM_PHI1: begin
        out_r.func_index       <= FI_W'(1);
        out_r.shape_value      <= RW'(phi1);
        out_r.shape_derivative <= HalfR;
        out_r.last_of_run      <= (order_r == FI_W'(1));
      end
      EM_BUB: begin
        out_r.func_index       <= j_r;
        out_r.shape_value      <= sat24(val_r);
        out_r.shape_derivative <= sat24(der_r);
        out_r.last_of_run      <= (j_r == order_r);
      end
      EM_ONE: begin
        out_r.func_index       <= FI_W'(0);
        out_r.shape_value      <= OneR;
        out_r.shape_derivative <= '0;
        out_r.last_of_run      <= 1'b1;
      end
      default: ;
    endcase
  end

  assign stat.ord_zero = (order_r == FI_W'(0));
  assign stat.ord_one  = (order_r == FI_W'(1));
  assign stat.not_last = (j_r != order_r);
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

`ifndef NO_ASSERTIONS
  // A bubble word's index never passes the clamped order.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit == EM_BUB) |-> (j_r <= order_r && j_r >= FI_W'(2)))
    else $error("bubble index out of range");

  // The bubble value is never negative and at most one quarter.
  a_bub_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(ctl.op) == OP_BUB && !$past(load)) |->
      (!bub_r[AW-1] && bub_r <= AW'(16384)))
    else $error("bubble value out of range");

  // A loaded point is always clamped to [-1, 1].
  a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    $past(load) |-> (x_r <= OneX && x_r >= MinX))
    else $error("point not clamped");
`endif

endmodule

// File: rtl/hierarchic_1d_shape_functions.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hierarchic_1d_shape_functions: hierarchical 1-D shape functions
// Linear end functions plus Chebyshev-times-bubble functions and their
// derivatives for one point, Q1.16 in and Q7.16 out, saturated.
//
//   channel  ports                        handshake
//   input    start, busy, in_item         taken when start is high, busy low
//   result   out_valid, out_item          one word per out_valid cycle
//
// Each point gives order+1 result words. The bubble loop is six microcode
// steps per function around the single registered 18x32 multiplier. Reset
// clears the step counter and the result strobe. The receiver cannot stall;
// words leave at once.
// ----------------------------------------------------------------------------
module hierarchic_1d_shape_functions #(
  parameter int MAX_ORDER = hier1d_pkg::MAX_ORDER_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  hier1d_pkg::in_t  in_item,
  output logic             out_valid,
  output hier1d_pkg::out_t out_item
);
  import hier1d_pkg::*;

  ctl_t ctl;
  stat_t stat;
  logic accept;

  assign accept = start && !busy;

  hier1d_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  hier1d_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .in_item   (in_item),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef NO_ASSERTIONS
  // Words only come out of a run that was in progress.
  a_word_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word outside a run");

  // More words are due while the run is not finished.
  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_of_run) |-> busy)
    else $error("run ended before its last word");

  // The last word of a run is not followed by another word at once. Order
  // one flags both end words as last, so the check starts at index one.
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last_of_run && out_item.func_index != FI_W'(0))
      |=> !out_valid)
    else $error("word right after last of run");

  // An accepted point makes the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("not busy after accepting a point");
`endif

endmodule
